>>> src/assert_macros.svh
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MCTW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/mctw_pkg.sv
// Shared types, codes and defaults of the multi-console text writer.
package mctw_pkg;

    localparam int CONSOLE_COUNT_DEF = 3;
    localparam int ROW_CELLS_DEF     = 80;
    localparam int VISIBLE_ROWS_DEF  = 25;
    localparam int TOTAL_CELLS_DEF   = 16384;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_OUT_W = 14;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ATTR    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CURSOR = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_CHAR  = 2'd0,
        OP_SCROLL_UP   = 2'd1,
        OP_SCROLL_DOWN = 2'd2,
        OP_SELECT      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXEC,
        ST_NL,
        ST_SCROLL,
        ST_DONE
    } t_state;

endpackage

>>> src/mctw_ram.sv
// Generic single-port-write, registered-read RAM.
module mctw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/multi_console_text_writer_core.sv
// Multi-console text writer: cursor, erase and scroll control for split text video memory.
// Each accepted beat reads the target console's cursor and view start from a small state
// RAM (registered read); an in-range beat updates them and writes them back before the next
// beat is taken. A scroll or select beat runs the load, execute and done steps; a character
// write, newline and backspace included, adds a scroll step, repeated per row the view
// scrolls to catch the cursor; a newline that moves to the next row adds a row-multiply
// step. A beat naming a console beyond the count goes straight to the done step and returns
// an all-zero result. A result that waits holds its beat in the done step until the result
// register frees up. The result register lets the next beat enter while a result waits.
// Console state after reset comes from per-entry valid bits, so no clearing pass runs.
module multi_console_text_writer_core #(
    parameter int CONSOLE_COUNT = mctw_pkg::CONSOLE_COUNT_DEF,
    parameter int ROW_CELLS     = mctw_pkg::ROW_CELLS_DEF,
    parameter int VISIBLE_ROWS  = mctw_pkg::VISIBLE_ROWS_DEF,
    parameter int TOTAL_CELLS   = mctw_pkg::TOTAL_CELLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [mctw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mctw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // console_index [1:0], char_code [9:2], zero [15:10]
    input  logic [mctw_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // operation [1:0]
    input  logic [mctw_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // mem_cell [13:0], mem_char [21:14], mem_attr [29:22], cursor_position [43:30],
    // display_start [57:44], zero [63:58]
    output logic [mctw_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // mem_write [0], display_update [1]
    output logic [mctw_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);

    import mctw_pkg::*;

    `include "assert_macros.svh"

    localparam int REGION_CELLS = TOTAL_CELLS / CONSOLE_COUNT;
    localparam int SCREEN_CELLS = ROW_CELLS * VISIBLE_ROWS;
    localparam int CW           = $clog2(TOTAL_CELLS + SCREEN_CELLS + 1);
    localparam int OFF_W        = $clog2(REGION_CELLS);
    localparam int AW           = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
    localparam int MUL_S        = OFF_W + $clog2(ROW_CELLS);
    localparam longint MUL_M    = ((64'd1 << MUL_S) + ROW_CELLS - 1) / ROW_CELLS;
    localparam int MW           = OFF_W + 1;
    localparam int PW           = OFF_W + MW;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CHAR_W-1:0]    r_ch, n_ch;
    logic                 r_in_range, n_in_range;
    logic [CW-1:0]        r_cur, n_cur;
    logic [CW-1:0]        r_vs, n_vs;
    logic [CW-1:0]        r_org, n_org;
    logic [CW-1:0]        r_end, n_end;
    logic                 r_wr, n_wr;
    logic [CW-1:0]        r_cell, n_cell;
    logic [CHAR_W-1:0]    r_mch, n_mch;
    logic [PW-1:0]        r_prod, n_prod;
    logic [IDX_W-1:0]     r_active, n_active;

    logic [ATTR_W-1:0]        r_attr;
    logic [CW-1:0]            r_first;
    logic [CONSOLE_COUNT-1:0] r_cur_vld;
    logic [CONSOLE_COUNT-1:0] r_vs_vld;

    logic                  r_out_vld, n_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;

    logic                 w_accept;
    logic                 w_in_idx_ok;
    logic [AW-1:0]        w_raddr;
    logic [AW-1:0]        w_addr;
    logic [2*CW-1:0]      w_rdata;
    logic [2*CW-1:0]      w_wdata;
    logic                 w_we;
    logic [CW-1:0]        w_org;
    logic [CW-1:0]        w_screen_end;
    logic                 w_below;
    logic                 w_room;
    logic                 w_can_load;
    logic [OFF_W-1:0]     w_quot;
    logic [CW-1:0]        w_cfg_cur;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_idx_ok     = (int'(i_s_axis_tdata[IDX_W-1:0]) < CONSOLE_COUNT);
    assign w_raddr         = AW'(i_s_axis_tdata[IDX_W-1:0]);
    assign w_addr          = AW'(r_idx);
    assign w_org           = CW'(r_idx) * CW'(REGION_CELLS);
    assign w_screen_end    = r_vs + CW'(SCREEN_CELLS);
    assign w_below         = (r_cur >= w_screen_end);
    assign w_room          = (w_screen_end < r_end);
    assign w_can_load      = !r_out_vld || i_m_axis_tready;
    assign w_quot          = OFF_W'(r_prod >> MUL_S);
    assign w_wdata         = {r_vs, r_cur};
    assign w_we            = (r_state == ST_DONE) && w_can_load && r_in_range;
    assign w_cfg_cur       = CW'(i_cfg_data);

    mctw_ram #(
        .WIDTH (2 * CW),
        .DEPTH (CONSOLE_COUNT),
        .AW    (AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_idx_ok ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == OP_WRITE_CHAR) begin
                    if ((r_ch == CODE_NEWLINE) && (r_cur + CW'(ROW_CELLS) < r_end)) begin
                        n_state = ST_NL;
                    end else begin
                        n_state = ST_SCROLL;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_NL: begin
                n_state = ST_SCROLL;
            end
            ST_SCROLL: begin
                if (!(w_below && w_room)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_op       = r_op;
        n_idx      = r_idx;
        n_ch       = r_ch;
        n_in_range = r_in_range;
        n_cur      = r_cur;
        n_vs       = r_vs;
        n_org      = r_org;
        n_end      = r_end;
        n_wr       = r_wr;
        n_cell     = r_cell;
        n_mch      = r_mch;
        n_prod     = r_prod;
        n_active   = r_active;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op       = t_op'(i_s_axis_tuser[OP_W-1:0]);
                    n_idx      = i_s_axis_tdata[IDX_W-1:0];
                    n_ch       = i_s_axis_tdata[IDX_W +: CHAR_W];
                    n_in_range = w_in_idx_ok;
                    n_wr       = 1'b0;
                end
            end
            ST_LOAD: begin
                n_org = w_org;
                n_end = w_org + CW'(REGION_CELLS);
                if (r_cur_vld[w_addr]) begin
                    n_cur = w_rdata[CW-1:0];
                end else if (r_idx == '0) begin
                    n_cur = r_first;
                end else begin
                    n_cur = w_org;
                end
                n_vs = r_vs_vld[w_addr] ? w_rdata[2*CW-1:CW] : w_org;
            end
            ST_EXEC: begin
                unique case (r_op)
                    OP_WRITE_CHAR: begin
                        if (r_ch == CODE_NEWLINE) begin
                            n_prod = PW'(OFF_W'(r_cur - r_org)) * PW'(MUL_M);
                        end else if (r_ch == CODE_BACKSPACE) begin
                            if (r_cur > r_org) begin
                                n_cur  = r_cur - CW'(1);
                                n_wr   = 1'b1;
                                n_cell = r_cur - CW'(1);
                                n_mch  = CODE_SPACE;
                            end
                        end else begin
                            if (r_cur + CW'(1) < r_end) begin
                                n_cur  = r_cur + CW'(1);
                                n_wr   = 1'b1;
                                n_cell = r_cur;
                                n_mch  = r_ch;
                            end
                        end
                    end
                    OP_SCROLL_UP: begin
                        if (r_vs > r_org) begin
                            n_vs = r_vs - CW'(ROW_CELLS);
                        end
                    end
                    OP_SCROLL_DOWN: begin
                        if (w_room) begin
                            n_vs = r_vs + CW'(ROW_CELLS);
                        end
                    end
                    OP_SELECT: begin
                        n_active = r_idx;
                    end
                endcase
            end
            ST_NL: begin
                n_cur = r_org + CW'(ROW_CELLS) * (CW'(w_quot) + CW'(1));
            end
            ST_SCROLL: begin
                if (w_below && w_room) begin
                    n_vs = r_vs + CW'(ROW_CELLS);
                end
            end
            ST_DONE: begin
                if (w_can_load) begin
                    n_out_vld  = 1'b1;
                    n_out_user = {r_in_range, r_wr};
                    n_out_data = '0;
                    if (r_wr) begin
                        n_out_data[13:0]  = CELL_OUT_W'(r_cell);
                        n_out_data[21:14] = r_mch;
                        n_out_data[29:22] = r_attr;
                    end
                    if (r_in_range) begin
                        n_out_data[43:30] = CELL_OUT_W'(r_cur);
                        n_out_data[57:44] = CELL_OUT_W'(r_vs);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_out_vld  <= 1'b0;
            r_attr     <= ATTR_RESET;
            r_first    <= '0;
            r_cur_vld  <= '0;
            r_vs_vld   <= '0;
            r_in_range <= 1'b0;
            r_wr       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_out_vld  <= n_out_vld;
            r_in_range <= n_in_range;
            r_wr       <= n_wr;
            if (w_we) begin
                r_cur_vld[w_addr] <= 1'b1;
                r_vs_vld[w_addr]  <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                priority if (i_cfg_index == CFG_CHAR_ATTR) begin
                    r_attr <= i_cfg_data[ATTR_W-1:0];
                end else if (i_cfg_index == CFG_FIRST_CURSOR) begin
                    r_first      <= (w_cfg_cur >= CW'(REGION_CELLS)) ?
                                    CW'(REGION_CELLS - 1) : w_cfg_cur;
                    r_cur_vld[0] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_ch       <= n_ch;
        r_cur      <= n_cur;
        r_vs       <= n_vs;
        r_org      <= n_org;
        r_end      <= n_end;
        r_cell     <= n_cell;
        r_mch      <= n_mch;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `MCTW_ASSERT(a_active_range, int'(r_active) < CONSOLE_COUNT, "bad active console")
    `MCTW_ASSERT(a_load_from_done, $rose(o_m_axis_tvalid) |-> $past(r_state == ST_DONE), "bad load")
    `MCTW_ASSERT(a_scroll_bounds, (r_state == ST_SCROLL) |-> (r_vs >= r_org && r_cur < r_end), "bounds")
    `MCTW_ASSERT_ALWAYS(a_write_in_range, w_we |-> r_in_range, "state write for an ignored console")

endmodule
